// ===== hw/rtl/vmix_env_pkg.sv =====
// Shared types and constants for the voice mixer with ADSR envelope.
// Used by the channel interfaces, the register block, the divider, the controller and the datapath.
// Depends on nothing.
`default_nettype none

package vmix_env_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

    // Fixed point unity, 1.0 = 65536.
    localparam logic [16:0] ONE_FX = 17'd65536;

    // Divider geometry: every quotient fits in 17 bits, the dividend in 49.
    localparam int DIV_Q_BITS   = 17;
    localparam int DIV_NUM_BITS = 49;

    // Configuration register file addressing.
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_IDX_BITS  = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IDLE    = 3'd4;

    // One input item.
    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] osc_a_sample;
        logic [11:0] osc_b_sample;
        logic [11:0] osc_c_sample;
        logic [2:0]  osc_enables;
        logic [16:0] velocity;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [11:0] voice_sample;
        logic        voice_active;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic note_on;
        logic note_off;
        logic capture;
        logic mix;
        logic vel;
        logic eval;
        logic mul;
        logic div_start;
        logic env;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_idle;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vmix_env_in_if.sv =====
// Input channel interface: valid/ready handshake carrying one command item.
// Depends on vmix_env_pkg.
`default_nettype none

interface vmix_env_in_if import vmix_env_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vmix_env_out_if.sv =====
// Output channel interface: valid/ready handshake carrying one sample item.
// Depends on vmix_env_pkg.
`default_nettype none

interface vmix_env_out_if import vmix_env_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vmix_env_regs.sv =====
// APB-style configuration registers: envelope times, sustain and idle level.
// Depends on vmix_env_pkg.
`default_nettype none

module vmix_env_regs import vmix_env_pkg::*; #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    output logic      [TIME_BITS-1:0]     attack_samples,
    output logic      [TIME_BITS-1:0]     decay_samples,
    output logic      [TIME_BITS-1:0]     release_samples,
    output logic      [16:0]              sustain_level,
    output logic      [11:0]              idle_level
);

    logic [TIME_BITS-1:0]    attack_reg;
    logic [TIME_BITS-1:0]    decay_reg;
    logic [TIME_BITS-1:0]    release_reg;
    logic [16:0]             sustain_reg;
    logic [11:0]             idle_reg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic                    wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;

    // Register writes; fields wider than the register are truncated.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= TIME_BITS'(480);
            decay_reg   <= TIME_BITS'(4800);
            release_reg <= TIME_BITS'(4800);
            sustain_reg <= 17'd32768;
            idle_reg    <= 12'd2048;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ATTACK:  attack_reg  <= pwdata[TIME_BITS-1:0];
                REG_DECAY:   decay_reg   <= pwdata[TIME_BITS-1:0];
                REG_RELEASE: release_reg <= pwdata[TIME_BITS-1:0];
                REG_SUSTAIN: sustain_reg <= pwdata[16:0];
                REG_IDLE:    idle_reg    <= pwdata[11:0];
                default:     ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (idx)
            REG_ATTACK:  prdata = 32'(attack_reg);
            REG_DECAY:   prdata = 32'(decay_reg);
            REG_RELEASE: prdata = 32'(release_reg);
            REG_SUSTAIN: prdata = 32'(sustain_reg);
            REG_IDLE:    prdata = 32'(idle_reg);
            default:     prdata = 32'd0;
        endcase
    end

    assign attack_samples  = attack_reg;
    assign decay_samples   = decay_reg;
    assign release_samples = release_reg;
    assign sustain_level   = sustain_reg;
    assign idle_level      = idle_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vmix_env_div.sv =====
// Restoring divider, one quotient bit per cycle, 17 quotient bits.
// The caller guarantees the quotient fits in 17 bits. Depends on vmix_env_pkg.
`default_nettype none

module vmix_env_div import vmix_env_pkg::*; #(
    parameter int DEN_BITS = 24
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DIV_NUM_BITS-1:0] dividend,
    input  wire logic [DEN_BITS-1:0]     divisor,
    output logic                         idle,
    output logic      [DIV_Q_BITS-1:0]   quotient
);

    localparam int CNT_BITS = $clog2(DIV_Q_BITS + 1);

    logic                  busy_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [DEN_BITS-1:0]   rem_reg;
    logic [DIV_Q_BITS-1:0] q_reg;
    logic [DEN_BITS:0]     rem_sh;
    logic [DEN_BITS:0]     diff;
    logic                  ge;

    // One step: bring down the next dividend bit and try a subtract.
    assign rem_sh = {rem_reg, q_reg[DIV_Q_BITS-1]};
    assign diff   = rem_sh - {1'b0, divisor};
    assign ge     = rem_sh >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(DIV_Q_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and the shared dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_BITS'(dividend[DIV_NUM_BITS-1:DIV_Q_BITS]);
            q_reg   <= dividend[DIV_Q_BITS-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
            q_reg   <= {q_reg[DIV_Q_BITS-2:0], ge};
        end
    end

    assign idle     = !busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vmix_env_dp.sv =====
// Datapath: voice state, oscillator mixer, velocity scaling, envelope update
// and the output register. Depends on vmix_env_pkg and vmix_env_div.
`default_nettype none

module vmix_env_dp import vmix_env_pkg::*; #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    input  wire in_item_t             item,
    input  wire logic [TIME_BITS-1:0] attack_samples,
    input  wire logic [TIME_BITS-1:0] decay_samples,
    input  wire logic [TIME_BITS-1:0] release_samples,
    input  wire logic [16:0]          sustain_level,
    input  wire logic [11:0]          idle_level,
    output out_item_t                 result,
    output logic                      result_valid,
    input  wire logic                 result_ready
);

    // Sample masks that follow from the sample width.
    localparam logic [11:0] SMP_MASK =
        (SAMPLE_BITS >= 12) ? 12'hFFF : 12'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam logic [15:0] SMP_MAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    // Reciprocal of three in 0.16 fixed point, exact for sums below 2^15.
    localparam logic [14:0] THIRD_FX = 15'd21846;

    // Envelope update cases.
    localparam logic [2:0] PH_HOLD = 3'd0;
    localparam logic [2:0] PH_OFF  = 3'd1;
    localparam logic [2:0] PH_REL  = 3'd2;
    localparam logic [2:0] PH_ATT  = 3'd3;
    localparam logic [2:0] PH_DEC  = 3'd4;
    localparam logic [2:0] PH_SUS  = 3'd5;

    // Voice state.
    logic [31:0] age_reg;
    logic [31:0] rel_start_reg;
    logic [16:0] env_reg;
    logic        gate_reg;
    logic        voice_reg;
    logic [16:0] vel_reg;

    // Captured item and intermediate values.
    logic [11:0]             osc_a_reg;
    logic [11:0]             osc_b_reg;
    logic [11:0]             osc_c_reg;
    logic [2:0]              en_reg;
    logic [11:0]             mix_reg;
    logic [11:0]             smp_reg;
    logic                    upd_reg;
    logic                    att_flag_reg;
    logic                    dec_flag_reg;
    logic [31:0]             age_a_reg;
    logic [31:0]             t_reg;
    logic [2:0]              phase_reg;
    logic [DIV_NUM_BITS-1:0] num_reg;
    logic [TIME_BITS-1:0]    den_reg;

    // Output register.
    out_item_t result_reg;
    logic      result_valid_reg;

    // Combinational helpers.
    logic [13:0]           mix_sum;
    logic [1:0]            mix_cnt;
    logic [28:0]           third_prod;
    logic [11:0]           mix_val;
    logic [28:0]           vel_prod;
    logic [11:0]           vel_sat;
    logic [31:0]           a32;
    logic [31:0]           d32;
    logic [31:0]           r32;
    logic                  rel_off;
    logic [2:0]            phase_sel;
    logic [31:0]           mul_a;
    logic [16:0]           mul_b;
    logic [TIME_BITS-1:0]  den_sel;
    logic [DIV_Q_BITS-1:0] quot;
    logic                  div_idle;
    logic [28:0]           out_prod;
    logic [11:0]           out_sat;

    assign a32 = 32'(attack_samples);
    assign d32 = 32'(decay_samples);
    assign r32 = 32'(release_samples);

    // Mixer: average of the enabled oscillators, idle level when none is on.
    assign mix_sum = (en_reg[0] ? {2'b00, osc_a_reg} : 14'd0)
                   + (en_reg[1] ? {2'b00, osc_b_reg} : 14'd0)
                   + (en_reg[2] ? {2'b00, osc_c_reg} : 14'd0);
    assign mix_cnt = {1'b0, en_reg[0]} + {1'b0, en_reg[1]} + {1'b0, en_reg[2]};
    assign third_prod = mix_sum * THIRD_FX;

    always_comb
    begin
        case (mix_cnt)
            2'd0:    mix_val = idle_level & SMP_MASK;
            2'd1:    mix_val = mix_sum[11:0];
            2'd2:    mix_val = mix_sum[12:1];
            default: mix_val = third_prod[27:16];
        endcase
    end

    // Velocity scaling with saturation.
    assign vel_prod = mix_reg * vel_reg;
    assign vel_sat  = ({3'b000, vel_prod[28:16]} > SMP_MAX) ? SMP_MAX[11:0]
                                                             : vel_prod[27:16];

    // Pick the envelope case and the operands of the shared multiplier.
    always_comb
    begin
        rel_off = (r32 == 32'd0) || (sustain_level == 17'd0) || (t_reg >= r32);
        if (!upd_reg)
        begin
            phase_sel = PH_HOLD;
        end
        else if (!gate_reg)
        begin
            phase_sel = rel_off ? PH_OFF : PH_REL;
        end
        else if (att_flag_reg)
        begin
            phase_sel = PH_ATT;
        end
        else if (dec_flag_reg)
        begin
            phase_sel = PH_DEC;
        end
        else
        begin
            phase_sel = PH_SUS;
        end

        case (phase_sel)
            PH_REL:
            begin
                mul_a   = t_reg;
                mul_b   = sustain_level;
                den_sel = release_samples;
            end
            PH_DEC:
            begin
                mul_a   = age_a_reg;
                mul_b   = ONE_FX - sustain_level;
                den_sel = decay_samples;
            end
            default:
            begin
                mul_a   = age_reg;
                mul_b   = ONE_FX;
                den_sel = attack_samples;
            end
        endcase
    end

    // Final output product with saturation.
    assign out_prod = smp_reg * env_reg;
    assign out_sat  = ({3'b000, out_prod[28:16]} > SMP_MAX) ? SMP_MAX[11:0]
                                                             : out_prod[27:16];

    vmix_env_div #(
        .DEN_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .idle     (div_idle),
        .quotient (quot)
    );

    // Voice state: note commands, age advance and envelope update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg       <= '0;
            rel_start_reg <= '0;
            env_reg       <= '0;
            gate_reg      <= 1'b0;
            voice_reg     <= 1'b0;
            vel_reg       <= '0;
        end
        else
        begin
            if (cmd.note_on)
            begin
                age_reg       <= '0;
                rel_start_reg <= '0;
                env_reg       <= '0;
                gate_reg      <= 1'b1;
                voice_reg     <= 1'b1;
                vel_reg       <= (item.velocity > ONE_FX) ? ONE_FX : item.velocity;
            end
            if (cmd.note_off)
            begin
                gate_reg      <= 1'b0;
                rel_start_reg <= age_reg;
            end
            if (cmd.mix && (age_reg != 32'hFFFF_FFFF))
            begin
                age_reg <= age_reg + 32'd1;
            end
            if (cmd.env)
            begin
                case (phase_reg)
                    PH_OFF:
                    begin
                        env_reg   <= '0;
                        voice_reg <= 1'b0;
                    end
                    PH_REL:  env_reg <= sustain_level - quot;
                    PH_ATT:  env_reg <= quot;
                    PH_DEC:  env_reg <= ONE_FX - quot;
                    PH_SUS:  env_reg <= sustain_level;
                    default: ;
                endcase
            end
        end
    end

    // Working registers of one sample item.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            osc_a_reg <= item.osc_a_sample & SMP_MASK;
            osc_b_reg <= item.osc_b_sample & SMP_MASK;
            osc_c_reg <= item.osc_c_sample & SMP_MASK;
            en_reg    <= item.osc_enables;
        end
        if (cmd.mix)
        begin
            mix_reg <= mix_val;
        end
        if (cmd.vel)
        begin
            smp_reg <= vel_sat;
        end
        if (cmd.eval)
        begin
            upd_reg      <= (sustain_level <= ONE_FX) && voice_reg;
            att_flag_reg <= age_reg < a32;
            dec_flag_reg <= {1'b0, age_reg} < ({1'b0, a32} + {1'b0, d32});
            age_a_reg    <= age_reg - a32;
            t_reg        <= (age_reg >= rel_start_reg) ? age_reg - rel_start_reg : 32'd0;
        end
        if (cmd.mul)
        begin
            phase_reg <= phase_sel;
            num_reg   <= mul_a * mul_b;
            den_reg   <= den_sel;
        end
    end

    // Output register: holds a finished item until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.voice_sample <= out_sat;
            result_reg.voice_active <= voice_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign sts.div_idle = div_idle;
    assign sts.out_free = !result_valid_reg || result_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/vmix_env_ctrl.sv =====
// Controller state machine: accepts command items and sequences the datapath.
// Depends on vmix_env_pkg.
`default_nettype none

module vmix_env_ctrl import vmix_env_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic [1:0] item_command,
    output logic            item_ready,
    input  wire dp_sts_t    sts,
    output dp_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MIX   = 4'd1;
    localparam logic [3:0] ST_VEL   = 4'd2;
    localparam logic [3:0] ST_EVAL  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_DIVGO = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_ENV   = 4'd7;
    localparam logic [3:0] ST_PROD  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Note commands finish in the accept cycle; a sample item walks the steps.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        item_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item_command)
                        CMD_NOTE_ON:  cmd.note_on  = 1'b1;
                        CMD_NOTE_OFF: cmd.note_off = 1'b1;
                        CMD_SAMPLE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_MIX;
                        end
                        default:      ;
                    endcase
                end
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_VEL;
            end
            ST_VEL:
            begin
                cmd.vel    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_idle)
                begin
                    state_next = ST_ENV;
                end
            end
            ST_ENV:
            begin
                cmd.env    = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/voice_mixer_adsr_envelope.sv =====
// Voice mixer with linear ADSR envelope. A sample item walks the mix, velocity,
// evaluate, multiply and envelope steps and the 17-step quotient loop of the
// divider; the next item is taken only after its result is loaded into the output.
// Note on, note off and unused commands finish when accepted and give no result.
// rst_n is asynchronous, active low: it clears the voice state and loads the
// register defaults; no clearing pass is needed.
`default_nettype none

module voice_mixer_adsr_envelope import vmix_env_pkg::*; #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 24
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    vmix_env_in_if.sink                   cmd_chan,
    vmix_env_out_if.source                smp_chan,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready
);

    logic [TIME_BITS-1:0] attack_samples;
    logic [TIME_BITS-1:0] decay_samples;
    logic [TIME_BITS-1:0] release_samples;
    logic [16:0]          sustain_level;
    logic [11:0]          idle_level;
    dp_cmd_t              dp_cmd;
    dp_sts_t              dp_sts;

    // Configuration registers.
    vmix_env_regs #(
        .TIME_BITS (TIME_BITS)
    ) u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .attack_samples  (attack_samples),
        .decay_samples   (decay_samples),
        .release_samples (release_samples),
        .sustain_level   (sustain_level),
        .idle_level      (idle_level)
    );

    // Sequencer.
    vmix_env_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (cmd_chan.valid),
        .item_command (cmd_chan.data.command),
        .item_ready   (cmd_chan.ready),
        .sts          (dp_sts),
        .cmd          (dp_cmd)
    );

    // Arithmetic and voice state.
    vmix_env_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .sts             (dp_sts),
        .item            (cmd_chan.data),
        .attack_samples  (attack_samples),
        .decay_samples   (decay_samples),
        .release_samples (release_samples),
        .sustain_level   (sustain_level),
        .idle_level      (idle_level),
        .result          (smp_chan.data),
        .result_valid    (smp_chan.valid),
        .result_ready    (smp_chan.ready)
    );

`ifndef SYNTH
    // A sample item keeps the block busy on the following cycle.
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_chan.valid && cmd_chan.ready && cmd_chan.data.command == CMD_SAMPLE)
        |=> !cmd_chan.ready)
        else $error("block took a new item right after a sample item");

    // Note commands never produce a result.
    a_no_result_for_note: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_chan.valid && cmd_chan.ready && cmd_chan.data.command != CMD_SAMPLE)
        |=> !$rose(smp_chan.valid))
        else $error("result appeared after a note command");

    // A result is never loaded over one that has not been taken.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> dp_sts.out_free)
        else $error("output register overwritten");

    // The divider is only started while idle.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.div_start |-> dp_sts.div_idle)
        else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire
